[design/complex_domain_color_pixel_top_defines.svh]
// Assertion macros for the complex-domain coloring design.
// Depends on nothing; each user supplies clk and rst in its own scope.
`ifndef COMPLEX_DOMAIN_COLOR_PIXEL_TOP_DEFINES_SVH
`define COMPLEX_DOMAIN_COLOR_PIXEL_TOP_DEFINES_SVH

// Same-cycle implication, reset masks the check.
`define CDC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masks the check.
`define CDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/cdc_pkg.sv]
// Shared types, constants and the arctangent table for the domain coloring block.
// Depends on nothing.
package cdc_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int LATENCY           = CORDIC_ITERATIONS + 4;
  localparam int STAGE_W           = 5;
  localparam int RED_BITS          = 8;

  localparam logic [15:0] MAG_SCALE = 16'd65025;

  localparam logic signed [33:0] QUARTER_TURN = 34'sh040000000;
  localparam logic signed [33:0] HALF_TURN    = 34'sh080000000;
  localparam logic signed [33:0] FULL_TURN    = 34'sh100000000;

  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic [12:0] FRAME_WIDTH_RESET  = 13'd640;
  localparam logic [12:0] FRAME_HEIGHT_RESET = 13'd480;

  // Payload handed from cell to cell.
  typedef struct packed {
    logic signed [26:0] x;
    logic signed [26:0] y;
    logic signed [33:0] z;
    logic               axis;
    logic [7:0]         root;
    logic [46:0]        rhs;
    logic               in_frame;
    logic [25:0]        offset;
  } cell_t;

  // atan(2^-i) in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input logic [STAGE_W-1:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

[design/cdc_front.sv]
// Front end: quadrant fold, squares, bounds check and frame offset over three stages.
// Depends on cdc_pkg.
module cdc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic signed [15:0]  real_part,
  input  logic signed [15:0]  imag_part,
  input  logic signed [15:0]  pixel_x,
  input  logic signed [15:0]  pixel_y,
  input  logic [12:0]         frame_width,
  input  logic [12:0]         frame_height,
  output logic                out_valid,
  output cdc_pkg::cell_t      out_cell
);
  import cdc_pkg::*;

  logic signed [26:0] re_ext, im_ext, x0, y0;
  logic signed [33:0] z0;
  logic               axis0, inside0;
  logic signed [31:0] re_sq0, im_sq0;
  logic [25:0]        prod0;

  // Stage 1
  logic               s1_valid;
  logic signed [26:0] s1_x, s1_y;
  logic signed [33:0] s1_z;
  logic               s1_axis, s1_inside;
  logic [31:0]        s1_re_sq, s1_im_sq;
  logic [25:0]        s1_prod;
  logic [12:0]        s1_px;

  // Stage 2
  logic               s2_valid;
  logic signed [26:0] s2_x, s2_y;
  logic signed [33:0] s2_z;
  logic               s2_axis, s2_inside;
  logic [31:0]        s2_m2;
  logic [25:0]        s2_base;

  always_comb begin
    re_ext = {{3{real_part[15]}}, real_part, 8'b0};
    im_ext = {{3{imag_part[15]}}, imag_part, 8'b0};
    x0     = re_ext;
    y0     = im_ext;
    z0     = '0;
    axis0  = 1'b0;
    if (imag_part == 16'sd0) begin
      axis0 = 1'b1;
      z0    = real_part[15] ? HALF_TURN : '0;
    end else if (real_part[15]) begin
      // fold the left half plane into the right one
      if (!imag_part[15]) begin
        x0 = im_ext;
        y0 = -re_ext;
        z0 = QUARTER_TURN;
      end else begin
        x0 = -im_ext;
        y0 = re_ext;
        z0 = -QUARTER_TURN;
      end
    end
    re_sq0  = real_part * real_part;
    im_sq0  = imag_part * imag_part;
    inside0 = !pixel_x[15] && (pixel_x[14:0] < {2'b00, frame_width}) &&
              !pixel_y[15] && (pixel_y[14:0] < {2'b00, frame_height});
    prod0   = pixel_y[12:0] * frame_width;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_x      <= x0;
    s1_y      <= y0;
    s1_z      <= z0;
    s1_axis   <= axis0;
    s1_inside <= inside0;
    s1_re_sq  <= $unsigned(re_sq0);
    s1_im_sq  <= $unsigned(im_sq0);
    s1_prod   <= prod0;
    s1_px     <= pixel_x[12:0];

    s2_x      <= s1_x;
    s2_y      <= s1_y;
    s2_z      <= s1_z;
    s2_axis   <= s1_axis;
    s2_inside <= s1_inside;
    s2_m2     <= s1_re_sq + s1_im_sq;
    s2_base   <= s1_inside ? (s1_prod + {13'b0, s1_px}) : '0;

    out_cell.x        <= s2_x;
    out_cell.y        <= s2_y;
    out_cell.z        <= s2_z;
    out_cell.axis     <= s2_axis;
    out_cell.root     <= '0;
    out_cell.rhs      <= 47'(s2_m2) * 47'(MAG_SCALE);
    out_cell.in_frame <= s2_inside;
    out_cell.offset   <= 26'({s2_base, 1'b0}) + s2_base;
  end

endmodule

[design/cdc_cell.sv]
// One cell of the chain: a CORDIC micro-rotation plus, in the first cells, one root bit.
// Depends on cdc_pkg.
module cdc_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [cdc_pkg::STAGE_W-1:0]   stage,
  input  logic                          in_valid,
  input  cdc_pkg::cell_t                in_cell,
  output logic                          out_valid,
  output cdc_pkg::cell_t                out_cell
);
  import cdc_pkg::*;

  logic signed [26:0] dx, dy;
  logic signed [33:0] step;
  logic [7:0]         trial;
  logic [15:0]        trial_sq;
  cell_t              cell_next;

  always_comb begin
    cell_next = in_cell;
    dx        = in_cell.y >>> stage;
    dy        = in_cell.x >>> stage;
    step      = $signed({2'b00, atan_turn(stage)});
    if (!in_cell.axis) begin
      if (in_cell.y > 27'sd0) begin
        cell_next.x = in_cell.x + dx;
        cell_next.y = in_cell.y - dy;
        cell_next.z = in_cell.z + step;
      end else begin
        cell_next.x = in_cell.x - dx;
        cell_next.y = in_cell.y + dy;
        cell_next.z = in_cell.z - step;
      end
    end
    // keep the root bit only if its square does not exceed the scaled magnitude
    trial    = in_cell.root | (8'h80 >> stage[2:0]);
    trial_sq = trial * trial;
    if ((stage < STAGE_W'(RED_BITS)) && ({7'b0, trial_sq, 24'b0} <= in_cell.rhs)) begin
      cell_next.root = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_cell <= cell_next;
  end

endmodule

[design/complex_domain_color_pixel_top.sv]
// Top level of the complex-domain coloring pixel block: config registers, chain, output.
// Depends on cdc_pkg, cdc_front, cdc_cell and complex_domain_color_pixel_top_defines.svh.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------------
//  input    | start, busy (always low)  | real_part, imag_part, pixel_x, pixel_y
//  result   | done (one-cycle strobe)   | red, green, blue, in_frame, byte_offset
//  config   | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// One transaction enters every cycle; each result passes, in order, through three front stages,
// one register per CORDIC cell and one output stage.
// The CORDIC chain length sets the depth of that path; the eight root-bit steps ride in the first cells.
// rst is synchronous and clears all valid flags and loads the frame size 640 x 480.
// The receiver cannot stall, so nothing holds the chain; config writes are always accepted and registered directly.
module complex_domain_color_pixel_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] real_part,
  input  logic signed [15:0] imag_part,
  input  logic signed [15:0] pixel_x,
  input  logic signed [15:0] pixel_y,
  output logic               done,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic               in_frame,
  output logic [25:0]        byte_offset,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data
);
  import cdc_pkg::*;
  `include "complex_domain_color_pixel_top_defines.svh"

  logic        accepted;
  logic [12:0] frame_width;
  logic [12:0] frame_height;

  // chain taps: entry 0 is the front end output, entry N the last cell
  logic  chain_valid [0:CORDIC_ITERATIONS];
  cell_t chain_cell  [0:CORDIC_ITERATIONS];

  logic signed [33:0] phase_u;
  logic [32:0]        phase_sat;
  logic [40:0]        green_prod;
  logic [7:0]         green_next;

  // the chain never stops, so a transaction is taken every cycle
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accepted  = start && !busy;

  // Config registers; writes to unknown indexes drop silently.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_FRAME_WIDTH) begin
        frame_width <= cfg_data;
      end
      if (cfg_index == CFG_FRAME_HEIGHT) begin
        frame_height <= cfg_data;
      end
    end
  end

  cdc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (accepted),
    .real_part    (real_part),
    .imag_part    (imag_part),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .out_valid    (chain_valid[0]),
    .out_cell     (chain_cell[0])
  );

  // Row of identical cells; each cell index picks its shift and table entry.
  for (genvar g = 0; g < CORDIC_ITERATIONS; g++) begin : g_cell
    cdc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .stage     (STAGE_W'(g)),
      .in_valid  (chain_valid[g]),
      .in_cell   (chain_cell[g]),
      .out_valid (chain_valid[g+1]),
      .out_cell  (chain_cell[g+1])
    );
  end

  // Map the angle from [-half, +half] turn onto [0, 1] turn and scale by 255.
  always_comb begin
    phase_u = chain_cell[CORDIC_ITERATIONS].z + HALF_TURN;
    if (phase_u < 34'sd0) begin
      phase_sat = '0;
    end else if (phase_u > FULL_TURN) begin
      phase_sat = FULL_TURN[32:0];
    end else begin
      phase_sat = phase_u[32:0];
    end
    green_prod = {phase_sat, 8'b0} - {8'b0, phase_sat};
    green_next = green_prod[39:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= chain_valid[CORDIC_ITERATIONS];
    end
  end

  // Output payload; the strobe alone marks it.
  always_ff @(posedge clk) begin
    red         <= chain_cell[CORDIC_ITERATIONS].root;
    green       <= green_next;
    blue        <= 8'hFF - chain_cell[CORDIC_ITERATIONS].root;
    in_frame    <= chain_cell[CORDIC_ITERATIONS].in_frame;
    byte_offset <= chain_cell[CORDIC_ITERATIONS].offset;
  end

  `CDC_ASSERT_IMPL(a_latency, accepted, ##LATENCY done, "result strobe missing after start")
  `CDC_ASSERT_IMPL(a_neg_axis, accepted && imag_part == 16'sd0 && real_part[15], ##LATENCY (green == 8'hFF), "negative real axis must give full green")
  `CDC_ASSERT_IMPL(a_zero, accepted && imag_part == 16'sd0 && real_part == 16'sd0, ##LATENCY (red == 8'd0 && green == 8'd127), "zero sample must give black red and mid green")
  `CDC_ASSERT_NEXT(a_off_zero, chain_valid[CORDIC_ITERATIONS] && !chain_cell[CORDIC_ITERATIONS].in_frame, byte_offset == 26'd0, "offset must be zero outside the frame")

endmodule
